FILE: src/psal_pkg.sv
// shared constants and types for the per-source attempt limiter
`default_nettype none
package psal_pkg;

   localparam int TableEntriesDefault = 64;
   localparam int MaxDelayMsDefault   = 30000;

   // register indexes
   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_LIMIT  = 3'd1;
   localparam logic [2:0] REG_WINDOW = 3'd2;
   localparam logic [2:0] REG_MODE   = 3'd3;
   localparam logic [2:0] REG_STEP   = 3'd4;
   localparam logic [2:0] REG_NET    = 3'd5;
   localparam logic [2:0] REG_PREFIX = 3'd6;

   // action modes
   localparam logic [1:0] MODE_BLOCK    = 2'd0;
   localparam logic [1:0] MODE_THROTTLE = 2'd1;
   localparam logic [1:0] MODE_LOG      = 2'd2;

   // verdicts
   localparam logic [1:0] VERDICT_ALLOW    = 2'd0;
   localparam logic [1:0] VERDICT_BLOCK    = 2'd1;
   localparam logic [1:0] VERDICT_THROTTLE = 2'd2;
   localparam logic [1:0] VERDICT_LOG      = 2'd3;

   typedef struct packed {
      logic        protect_enable;
      logic [15:0] attempt_limit;
      logic [31:0] window_seconds;
      logic [1:0]  action_mode;
      logic [14:0] throttle_step_ms;
      logic [31:0] allow_net;
      logic [5:0]  allow_prefix_len;
   } cfg_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] now_sec;
      logic        is_counted;
      logic        path_protected;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [14:0] delay_ms;
      logic [15:0] attempt_total;
      logic        table_full;
   } rsp_type;

   // queued item: request plus front-end classification
   typedef struct packed {
      req_type req;
      logic    bypass;
   } job_type;

endpackage
`default_nettype wire

FILE: src/psal_if.sv
// valid/ready channel interface
`default_nettype none
interface psal_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/per_source_attempt_limiter.sv
// top level of the per-source attempt limiter
//
//  channel | direction | handshake          | payload
//  req     | in        | valid/ready        | src_ip, now_sec, is_counted, path_protected
//  rsp     | out       | valid/ready        | verdict, delay_ms, attempt_total, table_full
//  csr     | in        | apb psel/penable   | seven registers at 4*index
//
// a protected item is scanned against the table ram one entry a cycle, then passes
// through the mul, read, write and out states; a bypassed item is answered from idle.
// synchronous reset clears the valid bits at once; no clearing pass.
// a two-item queue lets the front take items while the back scans or its result waits.
`default_nettype none
module per_source_attempt_limiter #(
   parameter int TableEntries = psal_pkg::TableEntriesDefault,
   parameter int MaxDelayMs   = psal_pkg::MaxDelayMsDefault
) (
   input  wire          clock,
   input  wire          reset,
   psal_if.sink         req,
   psal_if.source       rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire [4:0]    csr_paddr,
   input  wire [31:0]   csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   psal_pkg::cfg_type cfg;
   psal_pkg::job_type job;
   logic              job_valid, job_ready;

   psal_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_payload (req.payload),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job)
   );

   psal_back #(.TableEntries(TableEntries), .MaxDelayMs(MaxDelayMs)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_payload (rsp.payload)
   );
endmodule
`default_nettype wire

FILE: src/psal_ram.sv
// generic single-port ram with registered read
`default_nettype none
module psal_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire [$clog2(Depth)-1:0]     addr,
   input  wire [Width-1:0]             wr_data,
   output logic [Width-1:0]            rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: src/psal_front.sv
// front end: csr registers, whitelist check and two-entry queue
`default_nettype none
module psal_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire [4:0]              csr_paddr,
   input  wire [31:0]             csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output psal_pkg::cfg_type      cfg,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  psal_pkg::req_type      req_payload,
   output logic                   job_valid,
   input  wire                    job_ready,
   output psal_pkg::job_type      job
);
   psal_pkg::cfg_type cfg_ff;
   psal_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ptr_ff, wr_ptr_ff;
   logic [2:0] idx;
   logic [31:0] mask;
   logic       listed;
   psal_pkg::job_type in_job;
   logic       push, pop;

   assign idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protect_enable   <= 1'b0;
         cfg_ff.attempt_limit    <= 16'd10;
         cfg_ff.window_seconds   <= 32'd300;
         cfg_ff.action_mode      <= psal_pkg::MODE_BLOCK;
         cfg_ff.throttle_step_ms <= 15'd1000;
         cfg_ff.allow_net        <= 32'd0;
         cfg_ff.allow_prefix_len <= 6'd33;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            psal_pkg::REG_ENABLE: cfg_ff.protect_enable   <= csr_pwdata[0];
            psal_pkg::REG_LIMIT:  cfg_ff.attempt_limit    <= csr_pwdata[15:0];
            psal_pkg::REG_WINDOW: cfg_ff.window_seconds   <= csr_pwdata;
            psal_pkg::REG_MODE:   cfg_ff.action_mode      <= csr_pwdata[1:0];
            psal_pkg::REG_STEP:   cfg_ff.throttle_step_ms <= csr_pwdata[14:0];
            psal_pkg::REG_NET:    cfg_ff.allow_net        <= csr_pwdata;
            psal_pkg::REG_PREFIX: cfg_ff.allow_prefix_len <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         psal_pkg::REG_ENABLE: csr_prdata = {31'd0, cfg_ff.protect_enable};
         psal_pkg::REG_LIMIT:  csr_prdata = {16'd0, cfg_ff.attempt_limit};
         psal_pkg::REG_WINDOW: csr_prdata = cfg_ff.window_seconds;
         psal_pkg::REG_MODE:   csr_prdata = {30'd0, cfg_ff.action_mode};
         psal_pkg::REG_STEP:   csr_prdata = {17'd0, cfg_ff.throttle_step_ms};
         psal_pkg::REG_NET:    csr_prdata = cfg_ff.allow_net;
         psal_pkg::REG_PREFIX: csr_prdata = {26'd0, cfg_ff.allow_prefix_len};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // prefix 0 gives an all-zero mask
   always_comb begin
      if (cfg_ff.allow_prefix_len == 6'd0) begin
         mask = 32'd0;
      end else begin
         mask = 32'hFFFF_FFFF << (6'd32 - cfg_ff.allow_prefix_len);
      end
      listed = (cfg_ff.allow_prefix_len <= 6'd32) &&
               ((req_payload.src_ip & mask) == (cfg_ff.allow_net & mask));
      in_job.req    = req_payload;
      in_job.bypass = !cfg_ff.protect_enable || listed || !req_payload.path_protected;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_job;
      end
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: src/psal_back.sv
// back end: sequential table scan, update and result register
`default_nettype none
module psal_back #(
   parameter int TableEntries = psal_pkg::TableEntriesDefault,
   parameter int MaxDelayMs   = psal_pkg::MaxDelayMsDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  psal_pkg::cfg_type  cfg,
   input  wire                job_valid,
   output logic               job_ready,
   input  psal_pkg::job_type  job,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output psal_pkg::rsp_type  rsp_payload
);
   localparam int AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam int RamDepth = 1 << AW;
   localparam int CW = $clog2(TableEntries + 1);
   localparam logic [CW-1:0] Last = CW'(TableEntries - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]    state_ff;
   psal_pkg::req_type req_ff;
   logic [CW-1:0] idx_ff;
   logic          hit_ff, free_ff;
   logic [AW-1:0] hit_idx_ff, free_idx_ff;
   logic [15:0]   hit_cnt_ff;
   logic [TableEntries-1:0] valid_ff;
   logic [16:0]   excess_ff;
   logic [31:0]   prod_ff;
   logic [1:0]    verdict_ff;
   logic [15:0]   total_ff;
   logic          full_ff;
   logic [14:0]   delay_ff;
   logic          out_ff;

   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [79:0]   ram_wdata, ram_rdata;
   logic [31:0]   e_addr, e_start;
   logic [15:0]   e_cnt;
   logic          live;
   logic [15:0]   inc_cnt;

   assign e_addr  = ram_rdata[79:48];
   assign e_cnt   = ram_rdata[47:32];
   assign e_start = ram_rdata[31:0];

   psal_ram #(.Width(80), .Depth(RamDepth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign live = valid_ff[idx_ff[AW-1:0]] &&
                 ((req_ff.now_sec - e_start) < cfg.window_seconds);
   assign inc_cnt = (hit_cnt_ff == 16'hFFFF) ? hit_cnt_ff : hit_cnt_ff + 16'd1;

   assign job_ready = (state_ff == ST_IDLE) && !out_ff;
   assign rsp_valid = out_ff;
   assign rsp_payload.verdict       = verdict_ff;
   assign rsp_payload.delay_ms      = delay_ff;
   assign rsp_payload.attempt_total = total_ff;
   assign rsp_payload.table_full    = full_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = idx_ff[AW-1:0];
      ram_wdata = {req_ff.src_ip, 16'd1, req_ff.now_sec};
      case (state_ff)
         ST_IDLE: begin
            ram_addr = '0;
         end
         ST_READ: begin
            ram_addr = hit_idx_ff;
         end
         ST_CHECK: begin
            ram_addr = idx_ff[AW-1:0] + AW'(1);
         end
         ST_WRITE: begin
            if (hit_ff) begin
               ram_addr  = hit_idx_ff;
               ram_we    = 1'b1;
               ram_wdata = {req_ff.src_ip, total_ff, e_start};
            end else begin
               ram_addr = free_idx_ff;
               ram_we   = free_ff && req_ff.is_counted;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (out_ff && rsp_ready) begin
            out_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid && job_ready) begin
                  req_ff <= job.req;
                  if (job.bypass) begin
                     verdict_ff <= psal_pkg::VERDICT_ALLOW;
                     delay_ff   <= '0;
                     total_ff   <= '0;
                     full_ff    <= 1'b0;
                     out_ff     <= 1'b1;
                  end else begin
                     idx_ff   <= '0;
                     hit_ff   <= 1'b0;
                     free_ff  <= 1'b0;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               // entry hold for idx_ff sits on ram_rdata
               if (live) begin
                  if (!hit_ff && e_addr == req_ff.src_ip) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= idx_ff[AW-1:0];
                     hit_cnt_ff <= e_cnt;
                  end
               end else if (!free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff[AW-1:0];
               end
               if (idx_ff == Last) begin
                  state_ff <= ST_MUL;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            ST_MUL: begin
               verdict_ff <= psal_pkg::VERDICT_ALLOW;
               delay_ff   <= '0;
               full_ff    <= 1'b0;
               total_ff   <= '0;
               excess_ff  <= {1'b0, hit_cnt_ff} - {1'b0, cfg.attempt_limit} + 17'd1;
               if (hit_ff) begin
                  if (hit_cnt_ff >= cfg.attempt_limit) begin
                     total_ff <= inc_cnt;
                     case (cfg.action_mode)
                        psal_pkg::MODE_BLOCK:    verdict_ff <= psal_pkg::VERDICT_BLOCK;
                        psal_pkg::MODE_THROTTLE: verdict_ff <= psal_pkg::VERDICT_THROTTLE;
                        default:                 verdict_ff <= psal_pkg::VERDICT_LOG;
                     endcase
                  end else begin
                     total_ff <= req_ff.is_counted ? inc_cnt : hit_cnt_ff;
                  end
               end else if (req_ff.is_counted) begin
                  total_ff <= free_ff ? 16'd1 : 16'd0;
                  full_ff  <= !free_ff;
               end
               state_ff <= ST_READ;
            end
            ST_READ: begin
               // hit entry read so start time can be kept
               prod_ff  <= 32'(cfg.throttle_step_ms) * {15'd0, excess_ff};
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (verdict_ff == psal_pkg::VERDICT_THROTTLE) begin
                  delay_ff <= (prod_ff > 32'(MaxDelayMs)) ? 15'(MaxDelayMs)
                                                          : prod_ff[14:0];
               end
               if (!hit_ff && free_ff && req_ff.is_counted) begin
                  valid_ff[free_idx_ff] <= 1'b1;
               end
               out_ff   <= 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// testbench for the per-source attempt limiter: directed table, random phases, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int Entries = 64;
   localparam int MaxDelay = 30000;
   localparam int RandomItems = 700;
   localparam int CycleLimit = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire [31:0] csr_prdata;
   wire csr_pready;

   psal_if #(.payload_type(psal_pkg::req_type)) req_ch ();
   psal_if #(.payload_type(psal_pkg::rsp_type)) rsp_ch ();

   per_source_attempt_limiter uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   psal_pkg::cfg_type cfg;
   logic        tbl_valid [Entries];
   logic [31:0] tbl_addr  [Entries];
   logic [15:0] tbl_count [Entries];
   logic [31:0] tbl_start [Entries];

   psal_pkg::rsp_type verdicts_due [$];
   int error_count = 0;
   int cycle_count = 0;
   bit long_hold = 1'b0;
   bit hold_go = 1'b0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic on_whitelist(input logic [31:0] ip);
      logic [31:0] mask;
      if (cfg.allow_prefix_len > 6'd32) return 1'b0;
      mask = (cfg.allow_prefix_len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - cfg.allow_prefix_len);
      return (ip & mask) == (cfg.allow_net & mask);
   endfunction

   function automatic psal_pkg::rsp_type judge_request(input psal_pkg::req_type r);
      psal_pkg::rsp_type o;
      int hit, free_slot;
      logic [15:0] cur;
      logic [63:0] d;
      o = '0;
      hit = Entries;
      free_slot = Entries;
      if (cfg.protect_enable && !on_whitelist(r.src_ip) && r.path_protected) begin
         for (int i = 0; i < Entries; i++) begin
            if (tbl_valid[i] && (r.now_sec - tbl_start[i]) < cfg.window_seconds) begin
               if (tbl_addr[i] == r.src_ip && hit == Entries) hit = i;
            end else if (free_slot == Entries) begin
               free_slot = i;
            end
         end
         if (hit < Entries) begin
            cur = tbl_count[hit];
            if ({16'd0, cur} >= {16'd0, cfg.attempt_limit}) begin
               if (cur != 16'hFFFF) tbl_count[hit] = cur + 16'd1;
               if (cfg.action_mode == psal_pkg::MODE_BLOCK) begin
                  o.verdict = psal_pkg::VERDICT_BLOCK;
               end else if (cfg.action_mode == psal_pkg::MODE_THROTTLE) begin
                  d = 64'(cfg.throttle_step_ms) * (64'(cur) - 64'(cfg.attempt_limit) + 64'd1);
                  if (d > 64'(MaxDelay)) d = 64'(MaxDelay);
                  o.verdict = psal_pkg::VERDICT_THROTTLE;
                  o.delay_ms = d[14:0];
               end else begin
                  o.verdict = psal_pkg::VERDICT_LOG;
               end
            end else if (r.is_counted && cur != 16'hFFFF) begin
               tbl_count[hit] = cur + 16'd1;
            end
            o.attempt_total = tbl_count[hit];
         end else if (r.is_counted) begin
            if (free_slot < Entries) begin
               tbl_valid[free_slot] = 1'b1;
               tbl_addr[free_slot] = r.src_ip;
               tbl_count[free_slot] = 16'd1;
               tbl_start[free_slot] = r.now_sec;
               o.attempt_total = 16'd1;
            end else begin
               o.table_full = 1'b1;
            end
         end
      end
      return o;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         psal_pkg::REG_ENABLE: cfg.protect_enable = value[0];
         psal_pkg::REG_LIMIT:  cfg.attempt_limit = value[15:0];
         psal_pkg::REG_WINDOW: cfg.window_seconds = value;
         psal_pkg::REG_MODE:   cfg.action_mode = value[1:0];
         psal_pkg::REG_STEP:   cfg.throttle_step_ms = value[14:0];
         psal_pkg::REG_NET:    cfg.allow_net = value;
         psal_pkg::REG_PREFIX: cfg.allow_prefix_len = value[5:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (Entries + 10) @(posedge clock);
   endtask

   // offer one item, hold until accepted; valid stays high if another follows at once
   task automatic send_request(input psal_pkg::req_type r, input psal_pkg::rsp_type want,
                               input bit typed);
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (typed) begin
         verdicts_due.push_back(want);
         void'(judge_request(r));
      end else begin
         verdicts_due.push_back(judge_request(r));
      end
   endtask

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // well-formed traffic comes from a small pool of sources and a slowly moving clock
   logic [31:0] src_pool [8];
   logic [31:0] now_base;

   function automatic psal_pkg::req_type random_request();
      psal_pkg::req_type r;
      r.src_ip = ($urandom_range(0, 9) == 0) ? $urandom() : src_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 19) == 0) r.now_sec = $urandom();
      else r.now_sec = now_base + $urandom_range(0, 3);
      r.is_counted = ($urandom_range(0, 3) != 0);
      r.path_protected = ($urandom_range(0, 7) != 0);
      return r;
   endfunction

   typedef struct {
      psal_pkg::req_type r;
      bit                typed;
      psal_pkg::rsp_type want;
   } row_type;

   row_type rows [$];

   task automatic add_row(input logic [31:0] ip, input logic [31:0] t, input logic c,
                          input logic p, input bit typed, input psal_pkg::rsp_type want);
      row_type x;
      x.r = '{src_ip: ip, now_sec: t, is_counted: c, path_protected: p};
      x.typed = typed;
      x.want = want;
      rows.push_back(x);
   endtask

   task automatic random_phase(input int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 40) == 0) now_base = now_base + $urandom_range(1, 400);
         send_request(random_request(), '0, 1'b0);
         idle_gap();
      end
      req_ch.valid <= 1'b0;
   endtask

   // receiver: stall pattern plus one long hold-off
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (long_hold) rsp_ch.ready <= 1'b0;
         else if (phase % 64 < 20) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // long hold-off starts inside the first random phase, while items keep coming
   initial begin
      wait (hold_go == 1'b1);
      repeat (200) @(posedge clock);
      long_hold = 1'b1;
      repeat (1500) @(posedge clock);
      long_hold = 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      psal_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdicts_due.size() == 0) begin
            $display("unexpected item at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_ch.payload.verdict != want.verdict)
               report("verdict", 32'(rsp_ch.payload.verdict), 32'(want.verdict));
            if (rsp_ch.payload.delay_ms != want.delay_ms)
               report("delay_ms", 32'(rsp_ch.payload.delay_ms), 32'(want.delay_ms));
            if (rsp_ch.payload.attempt_total != want.attempt_total)
               report("attempt_total", 32'(rsp_ch.payload.attempt_total),
                      32'(want.attempt_total));
            if (rsp_ch.payload.table_full != want.table_full)
               report("table_full", 32'(rsp_ch.payload.table_full), 32'(want.table_full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   psal_pkg::rsp_type allow0, block_w, thr_cap, full_w;

   initial begin
      cfg = '{protect_enable: 1'b0, attempt_limit: 16'd10, window_seconds: 32'd300,
              action_mode: psal_pkg::MODE_BLOCK, throttle_step_ms: 15'd1000, allow_net: 32'd0,
              allow_prefix_len: 6'd33};
      for (int i = 0; i < Entries; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i] = '0;
         tbl_count[i] = '0;
         tbl_start[i] = '0;
      end
      for (int i = 0; i < 8; i++) src_pool[i] = $urandom();
      now_base = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      allow0 = '0;
      block_w = '{verdict: psal_pkg::VERDICT_BLOCK, delay_ms: 15'd0, attempt_total: 16'd2,
                  table_full: 1'b0};
      // disabled after reset: everything allowed, extremes of the fields
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, allow0);
      add_row(32'h0, 32'h0, 1'b0, 1'b0, 1'b1, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();

      // block mode, limit 1
      csr_write(psal_pkg::REG_ENABLE, 32'd1);
      csr_write(psal_pkg::REG_LIMIT, 32'd1);
      csr_write(psal_pkg::REG_WINDOW, 32'd100);
      csr_write(psal_pkg::REG_MODE, {30'd0, psal_pkg::MODE_BLOCK});
      add_row(32'h0A00_0001, 32'd1000, 1'b1, 1'b1, 1'b0, allow0);
      add_row(32'h0A00_0001, 32'd1001, 1'b0, 1'b1, 1'b1, block_w);
      add_row(32'h0A00_0001, 32'd1002, 1'b1, 1'b0, 1'b1, allow0);
      add_row(32'h0A00_0002, 32'd1002, 1'b0, 1'b1, 1'b1, allow0);
      add_row(32'h0A00_0001, 32'd1100, 1'b1, 1'b1, 1'b0, allow0);
      add_row(32'h0A00_0001, 32'd999, 1'b1, 1'b1, 1'b0, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();

      // throttle with large step: delay reaches the cap
      thr_cap = '{verdict: psal_pkg::VERDICT_THROTTLE, delay_ms: 15'd30000,
                  attempt_total: 16'd2, table_full: 1'b0};
      csr_write(psal_pkg::REG_MODE, {30'd0, psal_pkg::MODE_THROTTLE});
      csr_write(psal_pkg::REG_STEP, 32'd30000);
      csr_write(psal_pkg::REG_WINDOW, 32'hFFFF_FFFF);
      add_row(32'h0B00_0001, 32'd5, 1'b1, 1'b1, 1'b0, allow0);
      add_row(32'h0B00_0001, 32'd6, 1'b1, 1'b1, 1'b1, thr_cap);
      add_row(32'h0B00_0001, 32'd7, 1'b0, 1'b1, 1'b0, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();

      // log mode and mode 3, whitelist prefix 0 then 32
      csr_write(psal_pkg::REG_MODE, {30'd0, psal_pkg::MODE_LOG});
      add_row(32'h0B00_0001, 32'd8, 1'b0, 1'b1, 1'b0, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();
      csr_write(psal_pkg::REG_MODE, 32'd3);
      csr_write(psal_pkg::REG_NET, 32'hC0A8_0000);
      csr_write(psal_pkg::REG_PREFIX, 32'd0);
      add_row(32'h0B00_0001, 32'd9, 1'b1, 1'b1, 1'b1, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();
      csr_write(psal_pkg::REG_PREFIX, 32'd32);
      add_row(32'hC0A8_0000, 32'd9, 1'b1, 1'b1, 1'b1, allow0);
      add_row(32'h0B00_0001, 32'd10, 1'b0, 1'b1, 1'b0, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();

      // fill the table, then a new source sees table full; limit 0 and window 0 extremes
      csr_write(psal_pkg::REG_LIMIT, 32'd65535);
      full_w = '{verdict: psal_pkg::VERDICT_ALLOW, delay_ms: 15'd0, attempt_total: 16'd0,
                 table_full: 1'b1};
      for (int i = 0; i < Entries; i++) add_row(32'h2000_0000 + i, 32'd20, 1'b1, 1'b1, 1'b0, allow0);
      add_row(32'h3000_0000, 32'd21, 1'b1, 1'b1, 1'b1, full_w);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();
      csr_write(psal_pkg::REG_WINDOW, 32'd0);
      csr_write(psal_pkg::REG_LIMIT, 32'd0);
      add_row(32'h2000_0000, 32'd22, 1'b1, 1'b1, 1'b0, allow0);
      foreach (rows[i]) send_request(rows[i].r, rows[i].want, rows[i].typed);
      req_ch.valid <= 1'b0;
      rows.delete();
      settle();

      // random phases over several settings
      for (int ph = 0; ph < 7; ph++) begin
         csr_write(psal_pkg::REG_ENABLE, (ph == 0) ? 32'd1 : 32'($urandom_range(0, 5) != 0));
         csr_write(psal_pkg::REG_LIMIT, (ph == 6) ? 32'd65535 : $urandom_range(0, 6));
         csr_write(psal_pkg::REG_WINDOW, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 60));
         csr_write(psal_pkg::REG_MODE, ph % 4);
         csr_write(psal_pkg::REG_STEP, (ph == 4) ? 32'h7FFF : $urandom_range(0, 9000));
         csr_write(psal_pkg::REG_NET, src_pool[$urandom_range(0, 7)]);
         csr_write(psal_pkg::REG_PREFIX,
                   $urandom_range(0, 6) == 0 ? $urandom_range(0, 33) : 33);
         if (ph == 0) hold_go = 1'b1;
         random_phase(RandomItems / 7);
         settle();
      end

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (Entries + 20) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
